FILE: rtl/gscd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the glyph span command decoder.
// No dependencies.
package gscd_pkg;

    // opcode bytes of the command stream
    localparam logic [7:0] OP_SPAN = 8'h01 << 7;
    localparam logic [7:0] OP_RUN  = 8'h01 << 6;
    localparam logic [7:0] OP_END  = 8'h01 << 5;

    // field widths
    localparam int ORIGIN_W = 11;
    localparam int COORD_W  = 12;
    localparam int BYTE_W   = 8;
    localparam int COLOR_W  = 32;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 80;

    // decoder phase
    typedef enum logic [2:0] {
        PH_OPCODE,
        PH_X,
        PH_Y,
        PH_LEN,
        PH_DATA
    } phase_t;

    // result kind codes
    typedef enum logic [1:0] {
        KIND_PIXEL = 2'd0,
        KIND_RUN   = 2'd1,
        KIND_END   = 2'd2,
        KIND_BAD   = 2'd3
    } kind_t;

endpackage

FILE: rtl/glyph_span_command_decoder_unit.sv
`timescale 1ns / 1ps
// Glyph span command decoder top level: byte stream in, pixel/run/end/bad items out.
// Depends on gscd_pkg.
// A result is registered and appears on the master side in the cycle after its byte is taken.
// Throughput: one byte per cycle; a request is taken whenever the output register
// is empty or is being drained in the same cycle.
// Reset (rst_n low, asynchronous): decoder returns to opcode phase, output register
// empties, draw color becomes all ones.
module glyph_span_command_decoder_unit
(
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration: draw color
    input  logic                             cfg_we,
    input  logic [gscd_pkg::COLOR_W-1:0]     cfg_wdata,
    // slave side
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // span_byte [7:0], origin_x [18:8], origin_y [29:19], zero [31:30]
    input  logic [gscd_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // master side
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // pos_x [11:0], run_end_x [23:12], pos_y [35:24], coverage [43:36],
    // color [75:44], zero [79:76]
    output logic [gscd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // kind [1:0]
    output logic [1:0]                       m_axis_tuser,
    output logic                             m_axis_tlast
);
    import gscd_pkg::*;

    logic [COLOR_W-1:0]  color_reg;
    phase_t              phase_reg, phase_next;
    logic                is_run_reg, is_run_next;
    logic [COORD_W-1:0]  base_x_reg, base_x_next;
    logic [COORD_W-1:0]  base_y_reg, base_y_next;
    logic [BYTE_W-1:0]   len_reg, len_next;
    logic [BYTE_W-1:0]   cidx_reg, cidx_next;

    logic                out_valid_reg;
    kind_t               out_kind_reg, out_kind_next;
    logic [COORD_W-1:0]  out_px_reg, out_px_next;
    logic [COORD_W-1:0]  out_ex_reg, out_ex_next;
    logic [COORD_W-1:0]  out_py_reg, out_py_next;
    logic [BYTE_W-1:0]   out_cov_reg, out_cov_next;
    logic [COLOR_W-1:0]  out_color_reg;
    logic                out_last_reg, out_last_next;
    logic                out_load;

    logic                in_fire;
    logic [BYTE_W-1:0]   in_byte;
    logic [COORD_W-1:0]  in_ox, in_oy, byte_sx, pix_x;
    logic                span_last;

    // request unpacking
    assign in_byte = s_axis_tdata[7:0];
    assign in_ox   = {s_axis_tdata[18], s_axis_tdata[18:8]};
    assign in_oy   = {s_axis_tdata[29], s_axis_tdata[29:19]};
    assign byte_sx = {{(COORD_W-BYTE_W){in_byte[BYTE_W-1]}}, in_byte};
    assign pix_x   = base_x_reg + {{(COORD_W-BYTE_W){1'b0}}, cidx_reg};
    assign span_last = ({1'b0, cidx_reg} + 9'd1) >= {1'b0, len_reg};

    // handshake: output register drains or is empty
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // next decoder state
    always_comb
    begin
        phase_next  = phase_reg;
        is_run_next = is_run_reg;
        base_x_next = base_x_reg;
        base_y_next = base_y_reg;
        len_next    = len_reg;
        cidx_next   = cidx_reg;
        unique case (phase_reg)
            PH_OPCODE:
            begin
                if (in_byte == OP_SPAN || in_byte == OP_RUN)
                begin
                    is_run_next = (in_byte == OP_RUN);
                    base_x_next = in_ox;
                    base_y_next = in_oy;
                    len_next    = '0;
                    cidx_next   = '0;
                    phase_next  = PH_X;
                end
            end
            PH_X:
            begin
                base_x_next = base_x_reg + byte_sx;
                phase_next  = PH_Y;
            end
            PH_Y:
            begin
                base_y_next = base_y_reg + byte_sx;
                phase_next  = PH_LEN;
            end
            PH_LEN:
            begin
                len_next  = in_byte;
                cidx_next = '0;
                if (!is_run_reg && in_byte == '0)
                    phase_next = PH_OPCODE;
                else
                    phase_next = PH_DATA;
            end
            PH_DATA:
            begin
                if (is_run_reg)
                    phase_next = PH_OPCODE;
                else
                begin
                    cidx_next = cidx_reg + 8'd1;
                    if (span_last)
                        phase_next = PH_OPCODE;
                end
            end
            default:
            begin
                phase_next = PH_OPCODE;
            end
        endcase
    end

    // result generation
    always_comb
    begin
        out_load      = 1'b0;
        out_kind_next = KIND_BAD;
        out_px_next   = '0;
        out_ex_next   = '0;
        out_py_next   = '0;
        out_cov_next  = '0;
        out_last_next = 1'b1;
        unique case (phase_reg)
            PH_OPCODE:
            begin
                if (in_byte == OP_END)
                begin
                    out_load      = 1'b1;
                    out_kind_next = KIND_END;
                end
                else if (in_byte != OP_SPAN && in_byte != OP_RUN)
                begin
                    out_load      = 1'b1;
                    out_kind_next = KIND_BAD;
                end
            end
            PH_DATA:
            begin
                out_load     = 1'b1;
                out_py_next  = base_y_reg;
                out_cov_next = in_byte;
                if (is_run_reg)
                begin
                    out_kind_next = KIND_RUN;
                    out_px_next   = base_x_reg;
                    out_ex_next   = base_x_reg + {{(COORD_W-BYTE_W){1'b0}}, len_reg};
                end
                else
                begin
                    out_kind_next = KIND_PIXEL;
                    out_px_next   = pix_x;
                    out_ex_next   = pix_x;
                    out_last_next = span_last;
                end
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            color_reg <= '1;
        else if (cfg_we)
            color_reg <= cfg_wdata;
    end

    // decoder state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_OPCODE;
            is_run_reg <= 1'b0;
            base_x_reg <= '0;
            base_y_reg <= '0;
            len_reg    <= '0;
            cidx_reg   <= '0;
        end
        else if (in_fire)
        begin
            phase_reg  <= phase_next;
            is_run_reg <= is_run_next;
            base_x_reg <= base_x_next;
            base_y_reg <= base_y_next;
            len_reg    <= len_next;
            cidx_reg   <= cidx_next;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s_axis_tready)
            out_valid_reg <= in_fire && out_load;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (in_fire && out_load)
        begin
            out_kind_reg  <= out_kind_next;
            out_px_reg    <= out_px_next;
            out_ex_reg    <= out_ex_next;
            out_py_reg    <= out_py_next;
            out_cov_reg   <= out_cov_next;
            out_color_reg <= color_reg;
            out_last_reg  <= out_last_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {4'b0000, out_color_reg, out_cov_reg, out_py_reg,
                            out_ex_reg, out_px_reg};

    // operand bytes never produce a result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && (phase_reg == PH_X || phase_reg == PH_Y || phase_reg == PH_LEN)
        |=> !m_axis_tvalid)
        else $error("operand byte produced a result");

    // a run command ends after its single data byte
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && phase_reg == PH_DATA && is_run_reg |=> phase_reg == PH_OPCODE)
        else $error("run command did not return to opcode phase");

    // end and bad opcode results carry zero coverage and last
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && phase_reg == PH_OPCODE && out_load
        |=> m_axis_tvalid && m_axis_tlast && m_axis_tdata[43:36] == 8'd0)
        else $error("end or bad opcode result malformed");

    // span pixels advance the coverage index by one
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && phase_reg == PH_DATA && !is_run_reg
        |=> cidx_reg == $past(cidx_reg) + 8'd1)
        else $error("coverage index did not advance");

endmodule
